>>> rtl/scpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package scpq_pkg;

    localparam int DEPTH_DEF    = 64;
    localparam int KEY_BITS_DEF = 16;
    localparam int NODE_BITS    = 6;
    localparam int OP_BITS      = 2;
    localparam int STATUS_BITS  = 2;

    typedef enum logic [OP_BITS-1:0] {
        OP_APPEND  = 2'd0,
        OP_INSERT  = 2'd1,
        OP_DEQUEUE = 2'd2,
        OP_NOP     = 2'd3
    } t_op;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_CMP,
        S_DEQ
    } t_state;

    typedef struct packed {
        logic    done;
        t_status status;
    } t_rsp;

endpackage
`default_nettype wire

>>> rtl/scpq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module scpq_ram #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> rtl/scpq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module scpq_ctrl #(
    parameter int DEPTH    = scpq_pkg::DEPTH_DEF,
    parameter int KEY_BITS = scpq_pkg::KEY_BITS_DEF
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic                                      i_start,
    input  wire logic [scpq_pkg::OP_BITS-1:0]              i_opcode,
    input  wire logic [scpq_pkg::NODE_BITS-1:0]            i_node_id,
    input  wire logic [KEY_BITS-1:0]                       i_cost_key,
    input  wire logic [KEY_BITS-1:0]                       i_evaluate_key,
    input  wire logic                                      i_sort_sel,
    output logic                                           o_busy,
    output scpq_pkg::t_rsp                                 o_rsp,
    output logic [scpq_pkg::NODE_BITS-1:0]                 o_node,
    output logic [KEY_BITS-1:0]                            o_cost,
    output logic [KEY_BITS-1:0]                            o_eval,
    output logic [$clog2(DEPTH)-1:0]                       o_occ,
    output logic                                           o_ram_we,
    output logic [$clog2(DEPTH)-1:0]                       o_ram_waddr,
    output logic [scpq_pkg::NODE_BITS+2*KEY_BITS-1:0]      o_ram_wdata,
    output logic [$clog2(DEPTH)-1:0]                       o_ram_raddr,
    input  wire logic [scpq_pkg::NODE_BITS+2*KEY_BITS-1:0] i_ram_rdata
);
    import scpq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int EW = NODE_BITS + 2 * KEY_BITS;
    localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);
    localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);

    t_state                r_state, n_state;
    t_op                   r_op;
    logic [NODE_BITS-1:0]  r_node_in;
    logic [KEY_BITS-1:0]   r_cost_in, r_eval_in;
    logic [AW-1:0]         r_head, n_head, r_tail, n_tail, r_pos, n_pos;
    logic                  r_done, n_done;
    t_status               r_status, n_status;
    logic [NODE_BITS-1:0]  r_node;
    logic [KEY_BITS-1:0]   r_cost, r_eval;
    logic [AW-1:0]         r_occ;
    logic                  n_deq;

    logic [AW-1:0]         w_tail_next, w_head_next, w_pos_prev;
    logic                  w_full, w_empty, w_at_head, w_shift;
    logic [KEY_BITS-1:0]   w_new_key, w_ent_key, w_ent_cost, w_ent_eval;
    logic [NODE_BITS-1:0]  w_ent_node;
    logic [EW-1:0]         w_item;
    logic [AW:0]           w_occ_full;

    assign w_tail_next = (r_tail == LAST) ? '0 : r_tail + 1'b1;
    assign w_head_next = (r_head == LAST) ? '0 : r_head + 1'b1;
    assign w_pos_prev  = (r_pos == '0) ? LAST : r_pos - 1'b1;
    assign w_full      = (w_tail_next == r_head);
    assign w_empty     = (r_head == r_tail);
    assign w_at_head   = (r_pos == r_head);

    assign w_item     = {r_node_in, r_cost_in, r_eval_in};
    assign w_ent_node = i_ram_rdata[EW-1 -: NODE_BITS];
    assign w_ent_cost = i_ram_rdata[2*KEY_BITS-1 -: KEY_BITS];
    assign w_ent_eval = i_ram_rdata[KEY_BITS-1:0];
    assign w_new_key  = i_sort_sel ? r_eval_in : r_cost_in;
    assign w_ent_key  = i_sort_sel ? w_ent_eval : w_ent_cost;
    // strict compare keeps equal keys in arrival order
    assign w_shift    = (w_new_key < w_ent_key);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_op)
                    OP_INSERT:  n_state = w_full ? S_IDLE : S_SCAN;
                    OP_DEQUEUE: n_state = w_empty ? S_IDLE : S_DEQ;
                    default:    n_state = S_IDLE;
                endcase
            end
            S_SCAN: begin
                n_state = w_at_head ? S_IDLE : S_CMP;
            end
            S_CMP: begin
                n_state = w_shift ? S_SCAN : S_IDLE;
            end
            S_DEQ: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_pos       = r_pos;
        n_done      = 1'b0;
        n_status    = ST_OK;
        n_deq       = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_pos;
        o_ram_wdata = w_item;
        o_ram_raddr = w_pos_prev;
        case (r_state)
            S_EXEC: begin
                n_pos = r_tail;
                case (r_op)
                    OP_APPEND: begin
                        n_done = 1'b1;
                        if (w_full) begin
                            n_status = ST_FULL;
                        end else begin
                            o_ram_we    = 1'b1;
                            o_ram_waddr = r_tail;
                            n_tail      = w_tail_next;
                        end
                    end
                    OP_INSERT: begin
                        if (w_full) begin
                            n_done   = 1'b1;
                            n_status = ST_FULL;
                        end
                    end
                    OP_DEQUEUE: begin
                        o_ram_raddr = r_head;
                        if (w_empty) begin
                            n_done   = 1'b1;
                            n_status = ST_EMPTY;
                        end
                    end
                    default: begin
                        n_done = 1'b1;
                    end
                endcase
            end
            S_SCAN: begin
                if (w_at_head) begin
                    o_ram_we = 1'b1;
                    n_tail   = w_tail_next;
                    n_done   = 1'b1;
                end
            end
            S_CMP: begin
                o_ram_we = 1'b1;
                if (w_shift) begin
                    // move the larger entry one slot toward the tail
                    o_ram_wdata = i_ram_rdata;
                    n_pos       = w_pos_prev;
                end else begin
                    n_tail = w_tail_next;
                    n_done = 1'b1;
                end
            end
            S_DEQ: begin
                n_head = w_head_next;
                n_done = 1'b1;
                n_deq  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign w_occ_full = (n_tail >= n_head)
                      ? ({1'b0, n_tail} - {1'b0, n_head})
                      : ({1'b0, n_tail} + DEPTH_W - {1'b0, n_head});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_tail   <= '0;
            r_done   <= 1'b0;
            r_status <= ST_OK;
            r_occ    <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_done  <= n_done;
            if (n_done) begin
                r_status <= n_status;
                r_occ    <= w_occ_full[AW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        if (r_state == S_IDLE && i_start) begin
            r_op      <= t_op'(i_opcode);
            r_node_in <= i_node_id;
            r_cost_in <= i_cost_key;
            r_eval_in <= i_evaluate_key;
        end
        if (n_done) begin
            r_node <= n_deq ? w_ent_node : '0;
            r_cost <= n_deq ? w_ent_cost : '0;
            r_eval <= n_deq ? w_ent_eval : '0;
        end
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_rsp.done    = r_done;
    assign o_rsp.status  = r_status;
    assign o_node        = r_node;
    assign o_cost        = r_cost;
    assign o_eval        = r_eval;
    assign o_occ         = r_occ;

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_state == S_IDLE)
        else $error("result strobe while sequencer busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start) |=> r_state == S_EXEC)
        else $error("accepted request did not start execution");

    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_status == ST_FULL) |-> r_tail == $past(r_tail))
        else $error("refused insert moved tail");

    a_empty_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_status == ST_EMPTY) |-> (r_head == r_tail && r_occ == '0))
        else $error("empty status with entries held");

    a_shift_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP && w_shift) |=> (r_state == S_SCAN && r_tail == $past(r_tail)))
        else $error("shift step left scan or moved tail");
`endif

endmodule
`default_nettype wire

>>> rtl/sorted_circular_priority_queue_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Ports                                             Handshake
// request   i_opcode i_node_id i_cost_key i_evaluate_key      start & !busy
// result    o_status o_node_out o_cost_out o_evaluate_out     o_done (one cycle)
//           o_occupancy
// config    i_cfg_wr_data                                     i_cfg_wr_en
//
// Append, refused or ignored requests: result from the execute state; dequeue: from S_DEQ.
// Ordered insert: the walk ends at the head or at an entry with a key not above the
// new key; each shifted entry passes through S_SCAN and S_CMP for the registered read and
// then write of that shift through the entry RAM.
// Synchronous active-low reset empties the queue and clears the sort select.
// The result receiver cannot stall; busy holds off requests until the strobe.
module sorted_circular_priority_queue_top #(
    parameter int DEPTH    = scpq_pkg::DEPTH_DEF,
    parameter int KEY_BITS = scpq_pkg::KEY_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [scpq_pkg::OP_BITS-1:0]       i_opcode,
    input  wire logic [scpq_pkg::NODE_BITS-1:0]     i_node_id,
    input  wire logic [KEY_BITS-1:0]                i_cost_key,
    input  wire logic [KEY_BITS-1:0]                i_evaluate_key,
    input  wire logic                               i_cfg_wr_en,
    input  wire logic                               i_cfg_wr_data,
    output logic                                    o_done,
    output logic [scpq_pkg::STATUS_BITS-1:0]        o_status,
    output logic [scpq_pkg::NODE_BITS-1:0]          o_node_out,
    output logic [KEY_BITS-1:0]                     o_cost_out,
    output logic [KEY_BITS-1:0]                     o_evaluate_out,
    output logic [$clog2(DEPTH)-1:0]                o_occupancy
);
    import scpq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int EW = NODE_BITS + 2 * KEY_BITS;

    logic          r_sort_sel;
    t_rsp          w_rsp;
    logic          w_ram_we;
    logic [AW-1:0] w_ram_waddr, w_ram_raddr;
    logic [EW-1:0] w_ram_wdata, w_ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sort_sel <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_sort_sel <= i_cfg_wr_data;
        end
    end

    scpq_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    scpq_ctrl #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_opcode       (i_opcode),
        .i_node_id      (i_node_id),
        .i_cost_key     (i_cost_key),
        .i_evaluate_key (i_evaluate_key),
        .i_sort_sel     (r_sort_sel),
        .o_busy         (busy),
        .o_rsp          (w_rsp),
        .o_node         (o_node_out),
        .o_cost         (o_cost_out),
        .o_eval         (o_evaluate_out),
        .o_occ          (o_occupancy),
        .o_ram_we       (w_ram_we),
        .o_ram_waddr    (w_ram_waddr),
        .o_ram_wdata    (w_ram_wdata),
        .o_ram_raddr    (w_ram_raddr),
        .i_ram_rdata    (w_ram_rdata)
    );

    assign o_done   = w_rsp.done;
    assign o_status = w_rsp.status;

endmodule
`default_nettype wire

>>> dv/scpq_order_checker.sv
`timescale 1ns / 1ps
module scpq_order_checker #(
    parameter int DEPTH    = scpq_pkg::DEPTH_DEF,
    parameter int KEY_BITS = scpq_pkg::KEY_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic                                i_busy,
    input  logic [scpq_pkg::OP_BITS-1:0]        i_opcode,
    input  logic [scpq_pkg::NODE_BITS-1:0]      i_node_id,
    input  logic [KEY_BITS-1:0]                 i_cost_key,
    input  logic [KEY_BITS-1:0]                 i_evaluate_key,
    input  logic                                i_cfg_wr_en,
    input  logic                                i_cfg_wr_data,
    input  logic                                i_done,
    input  logic [scpq_pkg::STATUS_BITS-1:0]    i_status,
    input  logic [scpq_pkg::NODE_BITS-1:0]      i_node_out,
    input  logic [KEY_BITS-1:0]                 i_cost_out,
    input  logic [KEY_BITS-1:0]                 i_evaluate_out,
    input  logic [$clog2(DEPTH)-1:0]            i_occupancy,
    output int                                  o_mismatches,
    output int                                  o_outstanding
);
    import scpq_pkg::*;

    localparam int OCC_BITS = $clog2(DEPTH);

    typedef struct packed {
        logic [NODE_BITS-1:0] node;
        logic [KEY_BITS-1:0]  cost;
        logic [KEY_BITS-1:0]  eval;
    } t_entry;

    typedef struct packed {
        t_status             status;
        t_entry              data;
        logic [OCC_BITS-1:0] occ;
    } t_outcome;

    t_entry   slots [DEPTH];
    int       head_ptr = 0;
    int       tail_ptr = 0;
    logic     by_evaluate = 1'b0;
    t_outcome op_outcomes [$];
    int       mismatch_total = 0;

    function automatic logic [KEY_BITS-1:0] sort_key(input t_entry e);
        return by_evaluate ? e.eval : e.cost;
    endfunction

    function automatic t_outcome execute_op(input t_op op, input t_entry req);
        t_outcome res;
        int       pos;
        int       prv;
        logic     shifting;
        res = '0;
        if (op == OP_APPEND || op == OP_INSERT) begin
            if ((tail_ptr + 1) % DEPTH == head_ptr) begin
                res.status = ST_FULL;
            end else begin
                pos = tail_ptr;
                shifting = (op == OP_INSERT);
                // walk back from the tail, moving strictly larger keys up one slot
                while (shifting && pos != head_ptr) begin
                    prv = (pos + DEPTH - 1) % DEPTH;
                    if (sort_key(req) < sort_key(slots[prv])) begin
                        slots[pos] = slots[prv];
                        pos = prv;
                    end else begin
                        shifting = 1'b0;
                    end
                end
                slots[pos] = req;
                tail_ptr = (tail_ptr + 1) % DEPTH;
            end
        end else if (op == OP_DEQUEUE) begin
            if (head_ptr == tail_ptr) begin
                res.status = ST_EMPTY;
            end else begin
                res.data = slots[head_ptr];
                head_ptr = (head_ptr + 1) % DEPTH;
            end
        end
        res.occ = OCC_BITS'((tail_ptr + DEPTH - head_ptr) % DEPTH);
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_total < 100) begin
            $display("%0t: result %s mismatch: got 0x%0h, want 0x%0h",
                     $time, field, got, want);
        end
        mismatch_total++;
    endtask

    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            head_ptr = 0;
            tail_ptr = 0;
            by_evaluate = 1'b0;
            op_outcomes.delete();
        end else begin
            // retire the finished request before taking a new one on the same edge
            if (i_done) begin
                if (op_outcomes.size() == 0) begin
                    report_mismatch("strobe without request", 1, 0);
                end else begin
                    want = op_outcomes.pop_front();
                    if (i_status != want.status)
                        report_mismatch("status", 32'(i_status), 32'(want.status));
                    if (i_node_out != want.data.node)
                        report_mismatch("node_out", 32'(i_node_out), 32'(want.data.node));
                    if (i_cost_out != want.data.cost)
                        report_mismatch("cost_out", 32'(i_cost_out), 32'(want.data.cost));
                    if (i_evaluate_out != want.data.eval)
                        report_mismatch("evaluate_out", 32'(i_evaluate_out),
                                        32'(want.data.eval));
                    if (i_occupancy != want.occ)
                        report_mismatch("occupancy", 32'(i_occupancy), 32'(want.occ));
                end
            end
            if (i_start && !i_busy) begin
                op_outcomes.push_back(execute_op(t_op'(i_opcode),
                                      {i_node_id, i_cost_key, i_evaluate_key}));
            end
            if (i_cfg_wr_en) begin
                by_evaluate = i_cfg_wr_data;
            end
        end
        o_mismatches  <= mismatch_total;
        o_outstanding <= op_outcomes.size();
    end

endmodule

>>> dv/tb_sorted_circular_priority_queue_top.sv
`timescale 1ns / 1ps
module tb_sorted_circular_priority_queue_top;
    import scpq_pkg::*;

    localparam int DEPTH    = DEPTH_DEF;
    localparam int KEY_BITS = KEY_BITS_DEF;
    localparam int LIMIT    = 1_000_000;

    logic                          i_clk;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic [OP_BITS-1:0]            opcode = '0;
    logic [NODE_BITS-1:0]          node_id = '0;
    logic [KEY_BITS-1:0]           cost_key = '0;
    logic [KEY_BITS-1:0]           evaluate_key = '0;
    logic                          cfg_wr_en = 1'b0;
    logic                          cfg_wr_data = 1'b0;
    logic                          done;
    logic [STATUS_BITS-1:0]        status;
    logic [NODE_BITS-1:0]          node_out;
    logic [KEY_BITS-1:0]           cost_out;
    logic [KEY_BITS-1:0]           evaluate_out;
    logic [$clog2(DEPTH)-1:0]      occupancy;
    int                            mismatches;
    int                            outstanding;
    int                            idle_pct = 0;
    int unsigned                   cycle_count = 0;

    sorted_circular_priority_queue_top #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (opcode),
        .i_node_id      (node_id),
        .i_cost_key     (cost_key),
        .i_evaluate_key (evaluate_key),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .o_done         (done),
        .o_status       (status),
        .o_node_out     (node_out),
        .o_cost_out     (cost_out),
        .o_evaluate_out (evaluate_out),
        .o_occupancy    (occupancy)
    );

    scpq_order_checker #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS)
    ) i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_opcode       (opcode),
        .i_node_id      (node_id),
        .i_cost_key     (cost_key),
        .i_evaluate_key (evaluate_key),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_done         (done),
        .i_status       (status),
        .i_node_out     (node_out),
        .i_cost_out     (cost_out),
        .i_evaluate_out (evaluate_out),
        .i_occupancy    (occupancy),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("tb_sorted_circular_priority_queue_top NOT OK");
            $finish;
        end
    end

    task automatic issue(input t_op op, input logic [NODE_BITS-1:0] node,
                         input logic [KEY_BITS-1:0] cost, input logic [KEY_BITS-1:0] eval);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start        <= 1'b1;
        opcode       <= op;
        node_id      <= node;
        cost_key     <= cost;
        evaluate_key <= eval;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    task automatic write_sort_select(input logic sel);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= sel;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // favor tiny keys so ties and shifts over equal keys are common
    function automatic logic [KEY_BITS-1:0] pick_key();
        case ($urandom_range(0, 9))
            0:          return '0;
            1:          return '1;
            2, 3, 4, 5: return KEY_BITS'($urandom_range(0, 7));
            default:    return KEY_BITS'($urandom);
        endcase
    endfunction

    task automatic random_burst(input int deq_pct, input int count);
        int  issued;
        int  r;
        t_op op;
        issued = 0;
        while (issued < count) begin
            r = $urandom_range(0, 99);
            if (r < 3)
                op = OP_NOP;
            else if (r < 3 + deq_pct)
                op = OP_DEQUEUE;
            else if ($urandom_range(0, 9) < 7)
                op = OP_INSERT;
            else
                op = OP_APPEND;
            if ($urandom_range(0, 49) == 0)
                wait_for_results();
            issue(op, NODE_BITS'($urandom_range(0, 63)), pick_key(), pick_key());
            if (op != OP_NOP)
                issued++;
        end
    endtask

    // fill past full, mix, then drain past empty
    task automatic random_phase(input int gap_pct);
        idle_pct = gap_pct;
        random_burst(0, 66);
        random_burst(40, 6);
        random_burst(94, 66);
        wait_for_results();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_sort_select(1'b0);

        // sort by cost: empty and ignored requests, extremes, ties
        issue(OP_DEQUEUE, 6'd1, 16'h1234, 16'h4321);
        issue(OP_NOP, 6'd2, 16'hFFFF, 16'hFFFF);
        issue(OP_APPEND, 6'd63, 16'hFFFF, 16'hFFFF);
        issue(OP_APPEND, 6'd0, 16'h0000, 16'h0000);
        issue(OP_INSERT, 6'd5, 16'd100, 16'd9);
        issue(OP_INSERT, 6'd6, 16'd100, 16'd3);
        issue(OP_INSERT, 6'd7, 16'd0, 16'hFFFF);
        issue(OP_INSERT, 6'd8, 16'd50, 16'd0);
        issue(OP_NOP, 6'd9, 16'd1, 16'd1);
        repeat (7) issue(OP_DEQUEUE, 6'd0, 16'd0, 16'd0);
        wait_for_results();

        // sort by evaluate key
        write_sort_select(1'b1);
        issue(OP_INSERT, 6'd10, 16'd0, 16'd300);
        issue(OP_INSERT, 6'd11, 16'hFFFF, 16'd200);
        issue(OP_INSERT, 6'd12, 16'd1, 16'd300);
        issue(OP_INSERT, 6'd13, 16'hFFFF, 16'd0);
        issue(OP_INSERT, 6'd42, 16'd0, 16'hFFFF);
        repeat (6) issue(OP_DEQUEUE, 6'd0, 16'd0, 16'd0);
        wait_for_results();

        random_phase(18);
        write_sort_select(1'b0);
        random_phase(86);
        write_sort_select(1'b1);
        random_phase(0);

        repeat (2 * DEPTH + 8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_sorted_circular_priority_queue_top OK");
        end else begin
            $display("tb_sorted_circular_priority_queue_top NOT OK");
        end
        $finish;
    end

endmodule
